@@ src/tcld_pkg.sv @@
// Shared constants, phase codes and prefix match functions for the command line decoder.
package tcld_pkg;

    // Sizing
    localparam int MAX_LANE_COUNT = 8;
    localparam int LINE_CAPACITY  = 128;
    localparam int LEN_W          = $clog2(LINE_CAPACITY);
    localparam int LANE_W         = 4;
    localparam int PHASE_W        = 3;

    // Command codes on the result channel
    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_ARM   = 2'd1;
    localparam logic [1:0] CMD_LANES = 2'd2;

    // Scan phases
    localparam logic [PHASE_W-1:0] PH_SKIP_WS    = 3'd0;
    localparam logic [PHASE_W-1:0] PH_PREFIX     = 3'd1;
    localparam logic [PHASE_W-1:0] PH_CMD        = 3'd2;
    localparam logic [PHASE_W-1:0] PH_NUM_WS     = 3'd3;
    localparam logic [PHASE_W-1:0] PH_NUM_DIGITS = 3'd4;
    localparam logic [PHASE_W-1:0] PH_NUM_DONE   = 3'd5;
    localparam logic [PHASE_W-1:0] PH_DEAD       = 3'd6;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Prefix lengths
    localparam logic [3:0] LEN_RESET = 4'd5;
    localparam logic [3:0] LEN_ARM   = 4'd3;
    localparam logic [3:0] LEN_LANES = 4'd6;
    localparam logic [3:0] LEN_SET   = 4'd10;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'h20 : c;
    endfunction

    function automatic logic match_reset(input logic [3:0] pos, input logic [7:0] c);
        logic ok;
        unique case (pos)
            4'd0:    ok = (c == "R");
            4'd1:    ok = (c == "E");
            4'd2:    ok = (c == "S");
            4'd3:    ok = (c == "E");
            4'd4:    ok = (c == "T");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic match_arm(input logic [3:0] pos, input logic [7:0] c);
        logic ok;
        unique case (pos)
            4'd0:    ok = (c == "A");
            4'd1:    ok = (c == "R");
            4'd2:    ok = (c == "M");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // last character of the short form may be comma or space
    function automatic logic match_lanes(input logic [3:0] pos, input logic [7:0] c);
        logic ok;
        unique case (pos)
            4'd0:    ok = (c == "L");
            4'd1:    ok = (c == "A");
            4'd2:    ok = (c == "N");
            4'd3:    ok = (c == "E");
            4'd4:    ok = (c == "S");
            4'd5:    ok = (c == CH_COMMA) || (c == CH_SPACE);
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic match_set(input logic [3:0] pos, input logic [7:0] c);
        logic ok;
        unique case (pos)
            4'd0:    ok = (c == "S");
            4'd1:    ok = (c == "E");
            4'd2:    ok = (c == "T");
            4'd3:    ok = (c == "_");
            4'd4:    ok = (c == "L");
            4'd5:    ok = (c == "A");
            4'd6:    ok = (c == "N");
            4'd7:    ok = (c == "E");
            4'd8:    ok = (c == "S");
            4'd9:    ok = (c == ":");
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

@@ src/text_command_line_decoder_top.sv @@
// Top level of the text command line decoder: input register, parse stage, result register.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+-------------------------------
//  rx       | rx_valid / rx_ready          | rx_byte[7:0]
//  result   | result_valid / result_ready  | command_code[1:0], lane_count[3:0]
//
// One byte is taken every cycle unless a stalled result holds the parse stage; result_valid
// rises when the parse stage writes a command ended by CR or LF into the result register.
// rst_n clears the line state and both valid flags asynchronously.
// A result held on a stalled output stops the parse stage; the input register
// still takes one byte if it is empty, then rx_ready drops.
module text_command_line_decoder_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    output logic                       rx_ready,
    input  logic [7:0]                 rx_byte,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [1:0]                 command_code,
    output logic [tcld_pkg::LANE_W-1:0] lane_count
);
    import tcld_pkg::*;

    // Input register
    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;

    // Line state
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [3:0]         pos_reg, pos_next;
    logic [3:0]         alive_reg, alive_next;
    logic [LANE_W-1:0]  value_reg, value_next;
    logic               too_big_reg, too_big_next;
    logic               neg_reg, neg_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_code_reg;
    logic [LANE_W-1:0]  out_count_reg;

    logic               rx_fire, stage_fire;
    logic               res_valid;
    logic [1:0]         res_code;
    logic [LANE_W-1:0]  res_count;
    logic [7:0]         c, u;
    logic [3:0]         alive_m;
    logic [3:0]         pos_inc;
    logic [3:0]         digit;
    logic [7:0]         prod;
    logic               is_digit;

    // Handshake
    assign stage_fire = in_valid_reg && (!out_valid_reg || result_ready);
    assign rx_ready   = !in_valid_reg || stage_fire;
    assign rx_fire    = rx_valid && rx_ready;

    assign result_valid = out_valid_reg;
    assign command_code = out_code_reg;
    assign lane_count   = out_count_reg;

    // Per-byte decode helpers
    assign c        = in_byte_reg;
    assign u        = upcase(in_byte_reg);
    assign pos_inc  = pos_reg + 4'd1;
    assign is_digit = (c >= "0") && (c <= "9");
    assign digit    = c[3:0];
    assign prod     = {4'd0, value_reg} * 8'd10 + {4'd0, digit};
    assign alive_m  = {alive_reg[3] && match_set(pos_reg, u),
                       alive_reg[2] && match_lanes(pos_reg, u),
                       alive_reg[1] && match_arm(pos_reg, u),
                       alive_reg[0] && match_reset(pos_reg, u)};

    // Parse stage: next line state and result for the byte in the input register
    always_comb
    begin
        len_next     = len_reg;
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        alive_next   = alive_reg;
        value_next   = value_reg;
        too_big_next = too_big_reg;
        neg_next     = neg_reg;
        res_valid    = 1'b0;
        res_code     = CMD_RESET;
        res_count    = '0;

        if (c == CH_LF || c == CH_CR)
        begin
            // end of line: judge a non-empty line, then start afresh
            if (len_reg != '0)
            begin
                if (phase_reg == PH_CMD)
                begin
                    res_valid = 1'b1;
                    res_code  = alive_reg[0] ? CMD_RESET : CMD_ARM;
                end
                else if (phase_reg == PH_NUM_WS || phase_reg == PH_NUM_DIGITS ||
                         phase_reg == PH_NUM_DONE)
                begin
                    if (!too_big_reg && !neg_reg && value_reg != '0)
                    begin
                        res_valid = 1'b1;
                        res_code  = CMD_LANES;
                        res_count = value_reg;
                    end
                end
            end
            len_next     = '0;
            phase_next   = PH_SKIP_WS;
            pos_next     = '0;
            alive_next   = 4'hF;
            value_next   = '0;
            too_big_next = 1'b0;
            neg_next     = 1'b0;
        end
        else if (len_reg < LEN_W'(LINE_CAPACITY - 1))
        begin
            len_next = LEN_W'(len_reg + 1'b1);
            if (c == CH_NUL)
            begin
                // zero byte ends the parsed text
                if (phase_reg == PH_SKIP_WS || phase_reg == PH_PREFIX)
                    phase_next = PH_DEAD;
                else if (phase_reg == PH_NUM_WS || phase_reg == PH_NUM_DIGITS)
                    phase_next = PH_NUM_DONE;
            end
            else if ((phase_reg == PH_SKIP_WS && !is_blank(c)) || phase_reg == PH_PREFIX)
            begin
                // prefix match, first completed prefix wins
                pos_next   = pos_inc;
                phase_next = PH_PREFIX;
                priority if (alive_m == 4'd0)
                begin
                    alive_next = 4'd0;
                    phase_next = PH_DEAD;
                end
                else if (alive_m[0] && pos_inc == LEN_RESET)
                begin
                    alive_next = 4'b0001;
                    phase_next = PH_CMD;
                end
                else if (alive_m[1] && pos_inc == LEN_ARM)
                begin
                    alive_next = 4'b0010;
                    phase_next = PH_CMD;
                end
                else if (alive_m[2] && pos_inc == LEN_LANES)
                begin
                    alive_next = 4'b0100;
                    phase_next = PH_NUM_WS;
                end
                else if (alive_m[3] && pos_inc == LEN_SET)
                begin
                    alive_next = 4'b1000;
                    phase_next = PH_NUM_WS;
                end
                else
                begin
                    alive_next = alive_m;
                end
            end
            else if ((phase_reg == PH_NUM_WS && !is_blank(c)) || phase_reg == PH_NUM_DIGITS)
            begin
                // number: sign only before the first digit
                priority if (phase_reg == PH_NUM_WS && (c == CH_PLUS || c == CH_MINUS))
                begin
                    neg_next   = (c == CH_MINUS);
                    phase_next = PH_NUM_DIGITS;
                end
                else if (is_digit)
                begin
                    phase_next = PH_NUM_DIGITS;
                    if (!too_big_reg)
                    begin
                        if (prod > 8'(MAX_LANE_COUNT))
                            too_big_next = 1'b1;
                        else
                            value_next = prod[LANE_W-1:0];
                    end
                end
                else
                begin
                    phase_next = PH_NUM_DONE;
                end
            end
        end
        else
        begin
            // line too long: drop the byte and the line
            len_next     = '0;
            phase_next   = PH_SKIP_WS;
            pos_next     = '0;
            alive_next   = 4'hF;
            value_next   = '0;
            too_big_next = 1'b0;
            neg_next     = 1'b0;
        end
    end

    // Valid flags
    always_comb
    begin
        if (rx_fire)
            in_valid_next = 1'b1;
        else if (stage_fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (stage_fire && res_valid)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and line state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            len_reg       <= '0;
            phase_reg     <= PH_SKIP_WS;
            pos_reg       <= '0;
            alive_reg     <= 4'hF;
            value_reg     <= '0;
            too_big_reg   <= 1'b0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (stage_fire)
            begin
                len_reg     <= len_next;
                phase_reg   <= phase_next;
                pos_reg     <= pos_next;
                alive_reg   <= alive_next;
                value_reg   <= value_next;
                too_big_reg <= too_big_next;
                neg_reg     <= neg_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (rx_fire)
            in_byte_reg <= rx_byte;
        if (stage_fire && res_valid)
        begin
            out_code_reg  <= res_code;
            out_count_reg <= res_count;
        end
    end

endmodule

@@ src/tcld_checker.sv @@
// Port-level assertions for the command line decoder, bound to the top level.
module tcld_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        rx_valid,
    input logic                        rx_ready,
    input logic [7:0]                  rx_byte,
    input logic                        result_valid,
    input logic                        result_ready,
    input logic [1:0]                  command_code,
    input logic [tcld_pkg::LANE_W-1:0] lane_count
);
    import tcld_pkg::*;

    // only the three command codes are ever issued
    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (command_code == CMD_RESET || command_code == CMD_ARM ||
                          command_code == CMD_LANES))
        else $error("illegal command code");

    // reset and arm carry no lane count
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && command_code != CMD_LANES |-> lane_count == '0)
        else $error("lane count set on a non-lane command");

    // lane count within range for a lane command
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && command_code == CMD_LANES |->
            (lane_count != '0 && lane_count <= LANE_W'(MAX_LANE_COUNT)))
        else $error("lane count out of range");

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(command_code) && $stable(lane_count))
        else $error("result word changed while stalled");

endmodule

bind text_command_line_decoder_top tcld_checker u_tcld_checker (.*);

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text command line decoder: line predictor, scoreboard, stimulus.
import tcld_pkg::*;

typedef struct packed {
    logic [1:0]        code;
    logic [LANE_W-1:0] lanes;
} lane_cmd_t;

// Tracks the line being collected and checks decoded commands in order
class cmd_scoreboard;
    localparam int PFX_RESET = 0;
    localparam int PFX_ARM   = 1;
    localparam int PFX_LANES = 2;
    localparam int PFX_SET   = 3;

    lane_cmd_t          expected_cmds[$];
    int                 errors;
    int                 words_in;
    int                 cmds_checked;
    int                 cmd_hits[3];

    // running line state
    bit [LEN_W-1:0]     line_len;
    bit [PHASE_W-1:0]   phase;
    bit [3:0]           match_pos;
    bit [3:0]           alive;
    bit [LANE_W-1:0]    value;
    bit                 too_big;
    bit                 negative;

    function new();
        clear_line();
    endfunction

    function void clear_line();
        line_len  = '0;
        phase     = PH_SKIP_WS;
        match_pos = '0;
        alive     = 4'hF;
        value     = '0;
        too_big   = 1'b0;
        negative  = 1'b0;
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction

    function string prefix_text(int k);
        case (k)
            PFX_RESET: return "RESET";
            PFX_ARM:   return "ARM";
            PFX_LANES: return "LANES,";
            default:   return "SET_LANES:";
        endcase
    endfunction

    function bit prefix_char_ok(int k, int p, bit [7:0] u);
        string t;
        t = prefix_text(k);
        // short form takes a space in place of the comma
        if (k == PFX_LANES && p == 5)
            return (u == CH_COMMA) || (u == CH_SPACE);
        return (p < t.len()) && (u == t[p]);
    endfunction

    function bit blank(bit [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) || (c == CH_FF);
    endfunction

    function bit digit(bit [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function void advance_prefix(bit [7:0] c);
        bit [7:0] u;
        bit [3:0] survivors;
        string    t;
        u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
        survivors = '0;
        for (int k = 0; k < 4; k++)
            if (alive[k] && prefix_char_ok(k, match_pos, u))
                survivors[k] = 1'b1;
        alive = survivors;
        match_pos = match_pos + 1'b1;
        if (survivors == '0)
        begin
            phase = PH_DEAD;
            return;
        end
        // first completed prefix in priority order wins
        for (int k = 0; k < 4; k++)
        begin
            t = prefix_text(k);
            if (survivors[k] && match_pos == t.len())
            begin
                alive = 4'b0001 << k;
                phase = (k < 2) ? PH_CMD : PH_NUM_WS;
                return;
            end
        end
    endfunction

    function void add_digit(bit [7:0] c);
        int v;
        if (too_big)
            return;
        v = int'(value) * 10 + int'(c - "0");
        if (v > MAX_LANE_COUNT)
            too_big = 1'b1;
        else
            value = v[LANE_W-1:0];
    endfunction

    function void scan_byte(bit [7:0] c);
        // NUL ends the parsed text
        if (c == CH_NUL)
        begin
            if (phase == PH_SKIP_WS || phase == PH_PREFIX)
                phase = PH_DEAD;
            else if (phase == PH_NUM_WS || phase == PH_NUM_DIGITS)
                phase = PH_NUM_DONE;
            return;
        end
        case (phase)
            PH_SKIP_WS:
            begin
                if (!blank(c))
                begin
                    phase = PH_PREFIX;
                    advance_prefix(c);
                end
            end
            PH_PREFIX:
                advance_prefix(c);
            PH_NUM_WS:
            begin
                if (blank(c))
                    return;
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    negative = (c == CH_MINUS);
                    phase = PH_NUM_DIGITS;
                end
                else if (digit(c))
                begin
                    add_digit(c);
                    phase = PH_NUM_DIGITS;
                end
                else
                    phase = PH_NUM_DONE;
            end
            PH_NUM_DIGITS:
            begin
                if (digit(c))
                    add_digit(c);
                else
                    phase = PH_NUM_DONE;
            end
            default: ;
        endcase
    endfunction

    // Accepted input word: advance the line and queue any command it completes
    function void note_rx_byte(bit [7:0] c);
        lane_cmd_t cmd;
        words_in++;
        if (c == CH_LF || c == CH_CR)
        begin
            if (line_len != '0)
            begin
                if (phase == PH_CMD)
                begin
                    cmd.code  = alive[PFX_RESET] ? CMD_RESET : CMD_ARM;
                    cmd.lanes = '0;
                    expected_cmds.push_back(cmd);
                end
                else if (phase == PH_NUM_WS || phase == PH_NUM_DIGITS ||
                         phase == PH_NUM_DONE)
                begin
                    if (!too_big && !negative && value >= 1 && value <= MAX_LANE_COUNT)
                    begin
                        cmd.code  = CMD_LANES;
                        cmd.lanes = value;
                        expected_cmds.push_back(cmd);
                    end
                end
            end
            clear_line();
            return;
        end
        // overlong line: byte dropped, collecting restarts
        if (line_len < LINE_CAPACITY - 1)
        begin
            line_len = line_len + 1'b1;
            scan_byte(c);
        end
        else
            clear_line();
    endfunction

    task report(string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        errors++;
    endtask

    // Accepted result word: compare with the oldest queued command
    task check_command(logic [1:0] code, logic [LANE_W-1:0] lanes);
        lane_cmd_t want;
        if (expected_cmds.size() == 0)
        begin
            report($sformatf("unexpected result code %0d lanes %0d", code, lanes));
            return;
        end
        want = expected_cmds.pop_front();
        cmds_checked++;
        if (want.code <= CMD_LANES)
            cmd_hits[want.code]++;
        if (code !== want.code)
            report($sformatf("command_code %0d, wanted %0d", code, want.code));
        if (lanes !== want.lanes)
            report($sformatf("lane_count %0d, wanted %0d", lanes, want.lanes));
    endtask
endclass

module tb_top;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int RANDOM_WORDS = 1000;
    localparam int TAIL_CYCLES  = 10;
    localparam int IDLE_PCT     = 27;

    logic              clk;
    logic              rst_n;
    logic              rx_valid;
    logic              rx_ready;
    logic [7:0]        rx_byte;
    logic              result_valid;
    logic              result_ready;
    logic [1:0]        command_code;
    logic [LANE_W-1:0] lane_count;

    bit                calm;
    bit                hold_req;
    int                idle_cycles;
    int                lines_sent;
    bit [7:0]          line_buf[$];
    cmd_scoreboard     sb;

    text_command_line_decoder_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .command_code (command_code),
        .lane_count   (lane_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor both channels; watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_valid && rx_ready)
                sb.note_rx_byte(rx_byte);
            if (result_valid && result_ready)
                sb.check_command(command_code, lane_count);
        end
        if ((rx_valid && rx_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            result_ready = calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task send_byte(bit [7:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            rx_valid = 1'b0;
            @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte  = b;
        do
            @(posedge clk);
        while (!rx_ready);
        @(negedge clk);
    endtask

    task send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i]);
        line_buf.delete();
        lines_sent++;
    endtask

    function void put_text(string s, bit mix_case);
        bit [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (mix_case && ch >= "A" && ch <= "Z" && $urandom_range(1))
                ch = ch + 8'h20;
            line_buf.push_back(ch);
        end
    endfunction

    function void put_blanks(int n);
        bit [7:0] pick[4];
        pick = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
        repeat (n)
            line_buf.push_back(pick[$urandom_range(3)]);
    endfunction

    function void put_end();
        case ($urandom_range(3))
            0: line_buf.push_back(CH_CR);
            1: line_buf.push_back(CH_LF);
            default:
            begin
                line_buf.push_back(CH_CR);
                line_buf.push_back(CH_LF);
            end
        endcase
    endfunction

    function bit [7:0] any_char();
        return 8'($urandom_range(255));
    endfunction

    // One random line: mostly well-formed commands with random content
    function void build_line(bit force_long);
        int kind;
        int n;
        string t;
        bit [7:0] ch;
        kind = force_long ? 99 : $urandom_range(99);
        if (kind < 60)
        begin
            put_blanks($urandom_range(2));
            if (kind < 12)
                put_text("RESET", 1'b1);
            else if (kind < 24)
                put_text("ARM", 1'b1);
            else
            begin
                case ($urandom_range(2))
                    0: put_text("LANES,", 1'b1);
                    1: put_text("LANES ", 1'b1);
                    default: put_text("SET_LANES:", 1'b1);
                endcase
                put_blanks($urandom_range(3) == 0 ? $urandom_range(1, 3) : 0);
                case ($urandom_range(9))
                    0: line_buf.push_back(CH_PLUS);
                    1: line_buf.push_back(CH_MINUS);
                    default: ;
                endcase
                case ($urandom_range(9))
                    0: n = 0;
                    7: n = 2;
                    8: n = 3;
                    9: n = 4;
                    default: n = 1;
                endcase
                repeat (n)
                    line_buf.push_back(8'("0" + $urandom_range(9)));
            end
            if ($urandom_range(3) == 0)
                line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
            if ($urandom_range(9) == 0)
                line_buf.insert($urandom_range(line_buf.size()), CH_NUL);
        end
        else if (kind < 72)
        begin
            // prefix broken part-way through
            case ($urandom_range(3))
                0: t = "RESET";
                1: t = "ARM";
                2: t = "LANES,";
                default: t = "SET_LANES:";
            endcase
            put_text(t.substr(0, $urandom_range(t.len() - 1)), 1'b1);
            line_buf[line_buf.size() - 1] = 8'($urandom_range(8'h20, 8'h7E));
            repeat ($urandom_range(2))
                line_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end
        else if (kind < 98)
        begin
            repeat ($urandom_range(12))
                line_buf.push_back(any_char());
        end
        else
        begin
            // overlong line, then a command that may or may not survive the drop
            repeat ($urandom_range(118, 134))
            begin
                ch = any_char();
                if (ch == CH_CR || ch == CH_LF)
                    ch = "x";
                line_buf.push_back(ch);
            end
            put_text("ARM", 1'b1);
        end
        put_end();
    endfunction

    task send_text(string s, bit [7:0] term);
        put_text(s, 1'b0);
        line_buf.push_back(term);
        send_line();
    endtask

    // Stimulus
    initial
    begin
        int line_no;
        sb           = new();
        rst_n        = 1'b0;
        rx_valid     = 1'b0;
        rx_byte      = '0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        idle_cycles  = 0;
        lines_sent   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: each command, blanks, empty line, sign, overflow, NUL, top byte
        send_text("RESET", CH_LF);
        line_buf = '{CH_VT, CH_FF, CH_TAB, CH_SPACE};
        send_text("arm", CH_CR);
        send_text("", CH_LF);
        send_text("LANES,8", CH_LF);
        send_text("sEt_LaNeS: -3", CH_CR);
        send_text("Lanes 12", CH_LF);
        put_text("ARM", 1'b0);
        line_buf.push_back(CH_NUL);
        send_text("x", CH_LF);
        line_buf.push_back(8'hFF);
        send_text("", CH_LF);
        send_text("SET_LANES:+1", CH_CR);

        // Random lines, with one long result stall and one calm stretch
        line_no = 0;
        while (sb.words_in < RANDOM_WORDS + 80)
        begin
            if (line_no == 30)
                hold_req = 1'b1;
            calm = (line_no >= 150 && line_no < 200);
            build_line(line_no == 60);
            send_line();
            line_no++;
        end
        calm = 1'b0;
        rx_valid = 1'b0;

        // Drain, then watch for stray results
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d lines: commands, broken and noise lines, NULs,",
                 sb.words_in, lines_sent);
        $display({"overlong lines and a %0d-cycle result stall; checked %0d results ",
                  "(%0d reset, %0d arm, %0d set lanes), %0d mismatches."},
                 HOLD_CYCLES, sb.cmds_checked,
                 sb.cmd_hits[CMD_RESET], sb.cmd_hits[CMD_ARM],
                 sb.cmd_hits[CMD_LANES], sb.errors);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ text_command_line_decoder_top.f @@
src/tcld_pkg.sv
src/text_command_line_decoder_top.sv
src/tcld_checker.sv
verif/tb_top.sv
